[rtl/gpp_pkg.sv]
`default_nettype none
package gpp_pkg;

   typedef struct packed {
      logic load_n;
      logic set_p2;
      logic inc_p;
      logic load_v;
      logic sel_high;
      logic init_d;
      logic inc_d;
      logic mod_start;
      logic out_load;
      logic out_found;
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic n_odd;
      logic p_over;
      logic v_small;
      logic sq_gt_v;
      logic mod_done;
      logic rem_zero;
   } status_type;

endpackage
`default_nettype wire

[rtl/gpp_mod_unit.sv]
`default_nettype none
module gpp_mod_unit #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output logic                        done,
   output logic                        rem_zero
);

   localparam int CntWidth = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntWidth'(VALUE_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[VALUE_WIDTH-1:0]
                                            : trial[VALUE_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CntWidth'(1);
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule
`default_nettype wire

[rtl/gpp_datapath.sv]
`default_nettype none
module gpp_datapath
   import gpp_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   input  wire logic [VALUE_WIDTH-1:0] number,
   output status_type                  sts,
   output logic                        found,
   output logic [VALUE_WIDTH-1:0]      smaller_prime,
   output logic [VALUE_WIDTH-1:0]      larger_prime
);

   localparam int SqWidth = 2 * VALUE_WIDTH;

   logic [VALUE_WIDTH-1:0] n_ff, p_ff, v_ff, d_ff;
   logic [SqWidth-1:0]     sq_ff;
   logic                   found_ff;
   logic [VALUE_WIDTH-1:0] lo_ff, hi_ff;
   logic [VALUE_WIDTH-1:0] high_part;
   logic                   mod_done, mod_zero;

   assign high_part = n_ff - p_ff;

   gpp_mod_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .dividend (v_ff),
      .divisor  (d_ff),
      .done     (mod_done),
      .rem_zero (mod_zero)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_n) n_ff <= number;
      if (cmd.set_p2) p_ff <= VALUE_WIDTH'(2);
      else if (cmd.inc_p) p_ff <= p_ff + VALUE_WIDTH'(1);
      if (cmd.load_v) v_ff <= cmd.sel_high ? high_part : p_ff;
      if (cmd.init_d) begin
         d_ff  <= VALUE_WIDTH'(2);
         sq_ff <= SqWidth'(4);
      end else if (cmd.inc_d) begin
         d_ff  <= d_ff + VALUE_WIDTH'(1);
         sq_ff <= sq_ff + SqWidth'({d_ff, 1'b1});
      end
      if (cmd.out_load) begin
         found_ff <= cmd.out_found;
         lo_ff    <= cmd.out_found ? p_ff : '0;
         hi_ff    <= cmd.out_found ? high_part : '0;
      end
   end

   always_comb begin
      sts.n_small  = n_ff < VALUE_WIDTH'(4);
      sts.n_odd    = n_ff[0];
      sts.p_over   = p_ff > (n_ff >> 1);
      sts.v_small  = v_ff < VALUE_WIDTH'(2);
      sts.sq_gt_v  = sq_ff > SqWidth'(v_ff);
      sts.mod_done = mod_done;
      sts.rem_zero = mod_zero;
   end

   assign found         = found_ff;
   assign smaller_prime = lo_ff;
   assign larger_prime  = hi_ff;

endmodule
`default_nettype wire

[rtl/gpp_ctrl.sv]
`default_nettype none
module gpp_ctrl
   import gpp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type sts,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      TEST_INIT,
      TEST_LOOP,
      MOD_WAIT,
      STEP_P,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;
   logic      hit_ff, hit_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      is_prime, not_prime;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      is_prime     = 1'b0;
      not_prime    = 1'b0;
      cmd.sel_high = phase_ff;
      cmd.out_found = hit_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.load_n = 1'b1;
               cmd.set_p2 = 1'b1;
               state_in   = CHECK;
            end
         end
         CHECK: begin
            if (sts.n_small) begin
               hit_in   = 1'b0;
               state_in = FINISH;
            end else begin
               phase_in = sts.n_odd;
               state_in = TEST_INIT;
            end
         end
         TEST_INIT: begin
            cmd.load_v = 1'b1;
            cmd.init_d = 1'b1;
            state_in   = TEST_LOOP;
         end
         TEST_LOOP: begin
            priority if (sts.v_small) begin
               not_prime = 1'b1;
            end else if (sts.sq_gt_v) begin
               is_prime = 1'b1;
            end else begin
               cmd.mod_start = 1'b1;
               state_in      = MOD_WAIT;
            end
         end
         MOD_WAIT: begin
            if (sts.mod_done) begin
               if (sts.rem_zero) begin
                  not_prime = 1'b1;
               end else begin
                  cmd.inc_d = 1'b1;
                  state_in  = TEST_LOOP;
               end
            end
         end
         STEP_P: begin
            if (sts.p_over) begin
               hit_in   = 1'b0;
               state_in = FINISH;
            end else begin
               state_in = TEST_INIT;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      if (is_prime) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
            state_in = TEST_INIT;
         end else begin
            hit_in   = 1'b1;
            state_in = FINISH;
         end
      end
      if (not_prime) begin
         if (sts.n_odd) begin
            hit_in   = 1'b0;
            state_in = FINISH;
         end else begin
            cmd.inc_p = 1'b1;
            phase_in  = 1'b0;
            state_in  = STEP_P;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         phase_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/goldbach_prime_pair.sv]
// Channel   Dir  Handshake                 Payload
// req       in   req_tvalid / req_tready   number
// rsp       out  rsp_tvalid / rsp_tready   found, smaller_prime, larger_prime
//
// One word at a time. Each candidate v is tried against divisors up to sqrt(v), every
// remainder coming from the one-bit-per-cycle remainder unit; even numbers try candidates
// until the first pair, odd numbers test only number - 2.
// Synchronous active-high reset returns the controller to idle with no result pending.
// A stalled result is held in the output register while the next word is searched.
`default_nettype none
module goldbach_prime_pair
   import gpp_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // number
   input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // found, smaller_prime, larger_prime
   output logic [((2*VALUE_WIDTH+8)/8)*8-1:0]          rsp_tdata
);

   localparam int RspWidth = ((2 * VALUE_WIDTH + 8) / 8) * 8;

   cmd_type                cmd;
   status_type             sts;
   logic                   found;
   logic [VALUE_WIDTH-1:0] smaller_prime, larger_prime;

   gpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gpp_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .number        (req_tdata[VALUE_WIDTH-1:0]),
      .sts           (sts),
      .found         (found),
      .smaller_prime (smaller_prime),
      .larger_prime  (larger_prime)
   );

   assign rsp_tdata = RspWidth'({larger_prime, smaller_prime, found});

endmodule
`default_nettype wire

[rtl/gpp_checker.sv]
`default_nettype none
module gpp_checker #(
   parameter int VALUE_WIDTH = 16
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((2*VALUE_WIDTH+8)/8)*8-1:0]  rsp_tdata
);

   logic [VALUE_WIDTH-1:0] lo, hi;

   assign lo = rsp_tdata[VALUE_WIDTH:1];
   assign hi = rsp_tdata[2*VALUE_WIDTH:VALUE_WIDTH+1];

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken during search");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> lo == '0 && hi == '0)
      else $error("miss with nonzero primes");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> lo >= VALUE_WIDTH'(2) && lo <= hi)
      else $error("bad prime pair order");

endmodule

bind goldbach_prime_pair gpp_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_gpp_checker (.*);
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int W = 16;
   localparam int REQ_BITS = ((W + 7) / 8) * 8;
   localparam int RSP_BITS = ((2 * W + 8) / 8) * 8;
   localparam int IDLE_PCT = 38;
   localparam int WATCHDOG_LIMIT = 500000;
   localparam int RANDOM_WORDS = 120;

   typedef struct {
      logic         found;
      logic [W-1:0] smaller;
      logic [W-1:0] larger;
   } prime_split_type;

   typedef struct {
      logic [W-1:0] number;
      bit           drain;
   } number_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   number_word_type number_q[$];
   prime_split_type split_q[$];

   int accepted_count = 0;
   int checked_count = 0;
   int found_count = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   goldbach_prime_pair #(
      .VALUE_WIDTH(W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // number
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)    // found, smaller_prime, larger_prime
   );

   function automatic bit number_is_prime(int unsigned v);
      int unsigned d;
      if (v < 2) return 1'b0;
      for (d = 2; d * d <= v; d++) begin
         if (v % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic prime_split_type goldbach_split(logic [W-1:0] number);
      prime_split_type s;
      int unsigned n;
      int unsigned p;
      n = number;
      s.found = 1'b0;
      s.smaller = '0;
      s.larger = '0;
      if (n >= 4) begin
         if (n % 2 == 1) begin
            if (number_is_prime(n - 2)) begin
               s.found = 1'b1;
               s.smaller = W'(2);
               s.larger = W'(n - 2);
            end
         end else begin
            for (p = 2; p <= n / 2; p++) begin
               if (number_is_prime(p) && number_is_prime(n - p)) begin
                  s.found = 1'b1;
                  s.smaller = W'(p);
                  s.larger = W'(n - p);
                  break;
               end
            end
         end
      end
      return s;
   endfunction

   function automatic bit side_idles(int count);
      int pct;
      pct = (count >= 50 && count < 85) ? 0 : IDLE_PCT;
      return $urandom_range(0, 99) < pct;
   endfunction

   task automatic queue_number(logic [W-1:0] number, bit drain);
      number_word_type w;
      w.number = number;
      w.drain = drain;
      number_q.push_back(w);
   endtask

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      number_word_type next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            split_q.push_back(goldbach_split(req_tdata[W-1:0]));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            // hold off a draining word until every result is back
            if (number_q.size() == 0 || side_idles(accepted_count) ||
                (number_q[0].drain && (split_q.size() != 0 || req_tvalid))) begin
               req_tvalid <= 1'b0;
            end else begin
               next_word = number_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_BITS'(next_word.number);
            end
         end
      end
   end

   always @(posedge clock) begin
      prime_split_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (split_q.size() == 0) begin
               $error("result word with no number pending: %h", rsp_tdata);
               error_count++;
            end else begin
               want = split_q.pop_front();
               if (want.found) found_count++;
               if (rsp_tdata[0] !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[W:1] !== want.smaller) begin
                  $error("smaller_prime: expected %0d, got %0d",
                         want.smaller, rsp_tdata[W:1]);
                  error_count++;
               end
               if (rsp_tdata[2*W:W+1] !== want.larger) begin
                  $error("larger_prime: expected %0d, got %0d",
                         want.larger, rsp_tdata[2*W:W+1]);
                  error_count++;
               end
            end
         end
         rsp_tready <= !side_idles(checked_count);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [W-1:0] number;
      int pick;
      queue_number(W'(0), 1'b0);
      queue_number(W'(1), 1'b0);
      queue_number(W'(2), 1'b0);
      queue_number(W'(3), 1'b0);
      queue_number(W'(4), 1'b0);
      queue_number(W'(5), 1'b0);
      queue_number(W'(6), 1'b0);
      queue_number(W'(7), 1'b0);
      queue_number(W'(8), 1'b0);
      queue_number(W'(9), 1'b0);
      queue_number(W'(11), 1'b0);
      queue_number(W'(27), 1'b0);
      queue_number(W'(100), 1'b0);
      queue_number(W'(65535), 1'b0);
      queue_number(W'(65534), 1'b0);
      queue_number(W'(65523), 1'b0);
      queue_number(W'(65521), 1'b0);
      queue_number(W'(16'hAAAA), 1'b0);
      queue_number(W'(16'h5555), 1'b0);
      queue_number(W'(16'h8000), 1'b0);
      queue_number(W'(16'h7FFF), 1'b0);
      queue_number(W'(16'h7FFE), 1'b0);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 9);
         // keep most numbers small so the search stays short
         if (pick < 5) number = W'($urandom_range(0, 1023));
         else if (pick < 7) number = W'($urandom_range(0, 255));
         else number = W'($urandom_range(0, 65535));
         queue_number(number, i == 0 || i == 70);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (number_q.size() != 0 || req_tvalid) @(posedge clock);
      while (split_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("checked %0d results for %0d numbers: %0d split into primes, %0d with no pair",
               checked_count, accepted_count, found_count, checked_count - found_count);
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
